// File: rtl/battery_charge_estimator_macros.svh
// ----------------------------------------------------------------------------
// Battery charge estimator assertion macros
// Shared concurrent-assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_ESTIMATOR_MACROS_SVH
`define BATTERY_CHARGE_ESTIMATOR_MACROS_SVH

// same-cycle implication
`define BCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bce_pkg.sv
// ----------------------------------------------------------------------------
// Battery charge estimator package
// Widths, defaults, discharge curve tables and controller state type.
// ----------------------------------------------------------------------------
package bce_pkg;

	localparam int SAMPLES_PER_ESTIMATE = 32;
	localparam int CURVE_POINTS         = 11;

	localparam int SAMPLE_W = 12;   // ADC reading
	localparam int PCT_W    = 7;    // percent result
	localparam int MV_W     = 13;   // millivolts
	localparam int SCL_W    = 16;   // average * 14
	localparam int NUM_W    = 19;   // interpolation numerator, <= 100 * 4200
	localparam int IDX_W    = 4;    // curve slot index, 16 slots
	localparam int DEN_W    = 13;   // divisor width of the serial divider

	localparam logic [DEN_W-1:0] SCALE_DEN = DEN_W'(9);
	localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
	localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(0);

	typedef enum logic [3:0] {
		ST_ACCUM,
		ST_DIV_AVG,
		ST_SCALE,
		ST_DIV_MV,
		ST_RANGE,
		ST_SEARCH,
		ST_MUL,
		ST_DIV_PCT,
		ST_OUT
	} bce_state_t;

	// curve voltage per slot, unused slots read zero
	function automatic logic [MV_W-1:0] curve_mv(input logic [IDX_W-1:0] idx);
		logic [MV_W-1:0] v;
		unique case (idx)
			4'd0:    v = MV_W'(4200);
			4'd1:    v = MV_W'(4050);
			4'd2:    v = MV_W'(3900);
			4'd3:    v = MV_W'(3850);
			4'd4:    v = MV_W'(3800);
			4'd5:    v = MV_W'(3750);
			4'd6:    v = MV_W'(3700);
			4'd7:    v = MV_W'(3650);
			4'd8:    v = MV_W'(3600);
			4'd9:    v = MV_W'(3500);
			4'd10:   v = MV_W'(3300);
			default: v = '0;
		endcase
		return v;
	endfunction

	// curve percentage per slot, unused slots read zero
	function automatic logic [PCT_W-1:0] curve_pct(input logic [IDX_W-1:0] idx);
		logic [PCT_W-1:0] p;
		unique case (idx)
			4'd0:    p = PCT_W'(100);
			4'd1:    p = PCT_W'(90);
			4'd2:    p = PCT_W'(80);
			4'd3:    p = PCT_W'(70);
			4'd4:    p = PCT_W'(60);
			4'd5:    p = PCT_W'(50);
			4'd6:    p = PCT_W'(40);
			4'd7:    p = PCT_W'(30);
			4'd8:    p = PCT_W'(20);
			4'd9:    p = PCT_W'(10);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

// File: rtl/battery_charge_estimator.sv
// ----------------------------------------------------------------------------
// Battery charge estimator
// Block-averages ADC readings and maps the voltage to a charge percentage.
// ----------------------------------------------------------------------------
// Each accepted adc_sample transfer adds into a running sum, one sample per
// cycle while in_ready is high. The SAMPLES_PER_ESTIMATE-th sample closes the
// block: in_ready then drops for the estimate, which runs on one shared
// restoring divider retiring one quotient bit per cycle (DIV_W = 19 with the
// defaults). The estimate steps are: average = sum / N, mV = avg * 14 / 9,
// a range check, a linear search of the curve one point per cycle, a
// shift-add multiply for the interpolation numerator, the final divide and
// a hand-off to the output register. Readings on or past either end of the
// curve skip the search, multiply and final divide. The result sits in an
// output register, so sampling of the next block resumes while that result
// waits for out_ready; only a second finished estimate stalls on an untaken
// first one.
// Readings at or above 4200 mV give 100 %, at or below 3300 mV give 0 %.
// ----------------------------------------------------------------------------
`include "battery_charge_estimator_macros.svh"

module battery_charge_estimator #(
	parameter int SAMPLES_PER_ESTIMATE = bce_pkg::SAMPLES_PER_ESTIMATE,
	parameter int CURVE_POINTS         = bce_pkg::CURVE_POINTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bce_pkg::SAMPLE_W-1:0] adc_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bce_pkg::PCT_W-1:0]  charge_percent,
	output logic [bce_pkg::MV_W-1:0]   battery_mv
);

	localparam int SAMPLE_W = bce_pkg::SAMPLE_W;
	localparam int PCT_W    = bce_pkg::PCT_W;
	localparam int MV_W     = bce_pkg::MV_W;
	localparam int SCL_W    = bce_pkg::SCL_W;
	localparam int NUM_W    = bce_pkg::NUM_W;
	localparam int IDX_W    = bce_pkg::IDX_W;
	localparam int DEN_W    = bce_pkg::DEN_W;

	// block sum never exceeds 4095 * N
	localparam int SUM_W  = SAMPLE_W + $clog2(SAMPLES_PER_ESTIMATE);
	localparam int CNT_W  = (SAMPLES_PER_ESTIMATE > 1) ? $clog2(SAMPLES_PER_ESTIMATE) : 1;
	localparam int DIV_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	localparam int STEP_W = $clog2(DIV_W);

	localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SAMPLES_PER_ESTIMATE - 1);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);
	localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(PCT_W - 1);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(CURVE_POINTS - 1);
	localparam logic [DEN_W-1:0]  BLOCK_DEN = DEN_W'(SAMPLES_PER_ESTIMATE);

	bce_pkg::bce_state_t state_q, state_d;

	// control
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  k_q;
	logic              out_valid_q;

	// datapath
	logic [DIV_W-1:0]  div_num_q;    // dividend in, quotient out; also multiply accumulator
	logic [DEN_W-1:0]  div_rem_q;
	logic [DEN_W-1:0]  div_den_q;
	logic [MV_W-1:0]   mv_q;
	logic [NUM_W-1:0]  hi_q;         // weight of the upper point, shifted per step
	logic [NUM_W-1:0]  lo_q;         // weight of the lower point, shifted per step
	logic [PCT_W-1:0]  pa_q;
	logic [PCT_W-1:0]  pb_q;
	logic [MV_W-1:0]   span_q;
	logic [PCT_W-1:0]  res_pct_q;
	logic [PCT_W-1:0]  out_pct_q;
	logic [MV_W-1:0]   out_mv_q;

	logic              in_xfer;
	logic              out_xfer;
	logic              blk_done;
	logic [SUM_W-1:0]  sum_nxt;
	logic [DEN_W:0]    trial;
	logic              trial_ge;
	logic [DEN_W-1:0]  rem_nxt;
	logic [DIV_W-1:0]  num_nxt;
	logic              div_last;
	logic              out_load;
	logic [SAMPLE_W-1:0] avg;
	logic [SCL_W-1:0]  scaled;
	logic [MV_W-1:0]   mv_hi_pt;
	logic [MV_W-1:0]   mv_lo_pt;
	logic              seg_hit;
	logic [DIV_W-1:0]  mul_add;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign blk_done = in_xfer && (cnt_q == CNT_LAST);
	assign sum_nxt  = sum_q + SUM_W'(adc_sample);

	// one restoring-division step: shift in the dividend's top bit
	assign trial    = {div_rem_q, div_num_q[DIV_W-1]};
	assign trial_ge = trial >= {1'b0, div_den_q};
	assign rem_nxt  = trial_ge ? DEN_W'(trial - {1'b0, div_den_q}) : trial[DEN_W-1:0];
	assign num_nxt  = {div_num_q[DIV_W-2:0], trial_ge};
	assign div_last = (step_q == DIV_LAST);

	// x14 = x16 - x2
	assign avg    = div_num_q[SAMPLE_W-1:0];
	assign scaled = SCL_W'({avg, 4'b0000}) - SCL_W'({avg, 1'b0});

	// curve segment below point k-1 and above point k
	assign mv_hi_pt = bce_pkg::curve_mv(k_q - IDX_W'(1));
	assign mv_lo_pt = bce_pkg::curve_mv(k_q);
	assign seg_hit  = mv_q > mv_lo_pt;

	assign mul_add = (pa_q[0] ? DIV_W'(hi_q) : '0) + (pb_q[0] ? DIV_W'(lo_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bce_pkg::ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			bce_pkg::ST_ACCUM: begin
				in_ready = 1'b1;
				if (blk_done) state_d = bce_pkg::ST_DIV_AVG;
			end
			bce_pkg::ST_DIV_AVG: begin
				if (div_last) state_d = bce_pkg::ST_SCALE;
			end
			bce_pkg::ST_SCALE: begin
				state_d = bce_pkg::ST_DIV_MV;
			end
			bce_pkg::ST_DIV_MV: begin
				if (div_last) state_d = bce_pkg::ST_RANGE;
			end
			bce_pkg::ST_RANGE: begin
				priority if (mv_q >= bce_pkg::curve_mv('0)) state_d = bce_pkg::ST_OUT;
				else if (mv_q <= bce_pkg::curve_mv(IDX_LAST)) state_d = bce_pkg::ST_OUT;
				else state_d = bce_pkg::ST_SEARCH;
			end
			bce_pkg::ST_SEARCH: begin
				// a flat segment takes the lower point's percent directly
				if (seg_hit) begin
					state_d = (mv_hi_pt == mv_lo_pt) ? bce_pkg::ST_OUT : bce_pkg::ST_MUL;
				end
			end
			bce_pkg::ST_MUL: begin
				if (step_q == MUL_LAST) state_d = bce_pkg::ST_DIV_PCT;
			end
			bce_pkg::ST_DIV_PCT: begin
				if (div_last) state_d = bce_pkg::ST_OUT;
			end
			bce_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = bce_pkg::ST_ACCUM;
				end
			end
			default: state_d = bce_pkg::ST_ACCUM;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				sum_q <= blk_done ? '0 : sum_nxt;
				cnt_q <= blk_done ? '0 : cnt_q + CNT_W'(1);
			end

			unique case (state_q)
				bce_pkg::ST_DIV_AVG, bce_pkg::ST_DIV_MV, bce_pkg::ST_DIV_PCT:
					step_q <= div_last ? '0 : step_q + STEP_W'(1);
				bce_pkg::ST_MUL:
					step_q <= (step_q == MUL_LAST) ? '0 : step_q + STEP_W'(1);
				default:
					step_q <= '0;
			endcase

			if (state_q == bce_pkg::ST_RANGE) k_q <= IDX_W'(1);
			else if (state_q == bce_pkg::ST_SEARCH && !seg_hit) k_q <= k_q + IDX_W'(1);

			if (out_load)      out_valid_q <= 1'b1;
			else if (out_xfer) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bce_pkg::ST_ACCUM: begin
				div_num_q <= DIV_W'(sum_nxt);
				div_rem_q <= '0;
				div_den_q <= BLOCK_DEN;
			end
			bce_pkg::ST_DIV_AVG: begin
				div_num_q <= num_nxt;
				div_rem_q <= rem_nxt;
			end
			bce_pkg::ST_SCALE: begin
				div_num_q <= DIV_W'(scaled);
				div_rem_q <= '0;
				div_den_q <= bce_pkg::SCALE_DEN;
			end
			bce_pkg::ST_DIV_MV: begin
				div_num_q <= num_nxt;
				div_rem_q <= rem_nxt;
				if (div_last) mv_q <= num_nxt[MV_W-1:0];
			end
			bce_pkg::ST_RANGE: begin
				res_pct_q <= (mv_q >= bce_pkg::curve_mv('0)) ? bce_pkg::PCT_FULL
					: bce_pkg::PCT_EMPTY;
			end
			bce_pkg::ST_SEARCH: begin
				hi_q      <= NUM_W'(mv_q - mv_lo_pt);
				lo_q      <= NUM_W'(mv_hi_pt - mv_q);
				span_q    <= mv_hi_pt - mv_lo_pt;
				pa_q      <= bce_pkg::curve_pct(k_q - IDX_W'(1));
				pb_q      <= bce_pkg::curve_pct(k_q);
				res_pct_q <= bce_pkg::curve_pct(k_q);
				div_num_q <= '0;
			end
			bce_pkg::ST_MUL: begin
				// pct_hi * hi_w + pct_lo * lo_w, one multiplier bit per step
				div_num_q <= div_num_q + mul_add;
				hi_q      <= {hi_q[NUM_W-2:0], 1'b0};
				lo_q      <= {lo_q[NUM_W-2:0], 1'b0};
				pa_q      <= pa_q >> 1;
				pb_q      <= pb_q >> 1;
				div_rem_q <= '0;
				div_den_q <= span_q;
			end
			bce_pkg::ST_DIV_PCT: begin
				div_num_q <= num_nxt;
				div_rem_q <= rem_nxt;
				if (div_last) res_pct_q <= num_nxt[PCT_W-1:0];
			end
			bce_pkg::ST_OUT: begin
				if (out_load) begin
					out_pct_q <= res_pct_q;
					out_mv_q  <= mv_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign charge_percent = out_pct_q;
	assign battery_mv     = out_mv_q;

	// closing a block clears the accumulator and starts the average divide
	`BCE_ASSERT_NXT(a_blk_clear, blk_done,
		(sum_q == '0) && (cnt_q == '0) && (state_q == bce_pkg::ST_DIV_AVG),
		"block close did not clear accumulator")
	// divider never runs against a zero divisor
	`BCE_ASSERT_IMP(a_div_den,
		(state_q == bce_pkg::ST_DIV_AVG) || (state_q == bce_pkg::ST_DIV_MV) ||
		(state_q == bce_pkg::ST_DIV_PCT), div_den_q != '0,
		"serial divide with zero divisor")
	// curve search stays inside the populated points
	`BCE_ASSERT_IMP(a_search_idx, state_q == bce_pkg::ST_SEARCH,
		(k_q != '0) && (k_q <= IDX_LAST), "curve search index out of range")
	// results never pass the full-charge mark
	`BCE_ASSERT_IMP(a_pct_max, out_valid_q, out_pct_q <= bce_pkg::PCT_FULL,
		"charge percent above full")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Battery charge estimator testbench
// Sends blocks of ADC samples over valid/ready and checks every charge
// estimate against an in-bench model of the block average, the 14/9 scaling
// and the discharge curve lookup. A directed table of blocks comes first
// (curve knees, full scale, zero, bit patterns), then random blocks, mostly
// near the curve, with random idling on both sides at first and none at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	localparam int SAMPLE_W             = bce_pkg::SAMPLE_W;
	localparam int PCT_W                = bce_pkg::PCT_W;
	localparam int MV_W                 = bce_pkg::MV_W;
	localparam int SAMPLES_PER_ESTIMATE = bce_pkg::SAMPLES_PER_ESTIMATE;

	localparam int MV_SCALE_NUM   = 14;
	localparam int MV_SCALE_DEN   = 9;
	localparam int KNEE_COUNT     = 11;
	localparam int MV_TOP         = 4200;
	localparam int MV_BOTTOM      = 3300;
	localparam int PCT_TOP        = 100;
	localparam int PCT_BOTTOM     = 0;
	localparam int DIRECTED_ROWS  = 19;
	localparam int RANDOM_BLOCKS  = 36;  // with idling
	localparam int CLEAN_BLOCKS   = 6;   // closing stretch, no idling
	localparam int HOLD_AT_BLOCK  = 10;  // receiver long hold starts here
	localparam int PAUSE_AT_BLOCK = 20;  // sender drains the result queue here
	localparam int RX_HOLD_CYCLES = 600; // covers two full estimates
	localparam int DRAIN_CYCLES   = 200; // longer than one estimate

	// one expected estimate
	typedef struct packed {
		logic [PCT_W-1:0] pct;
		logic [MV_W-1:0]  mv;
	} charge_reading_t;

	// one directed block: even samples = base, odd samples = base ^ flip
	typedef struct packed {
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] flip;
		logic                pinned;   // expected estimate typed in below
		logic [PCT_W-1:0]    pct;
		logic [MV_W-1:0]     mv;
	} block_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] adc_sample;
	logic                out_valid;
	logic                out_ready;
	logic [PCT_W-1:0]    charge_percent;
	logic [MV_W-1:0]     battery_mv;

	// predictor state, mirrors the block's accumulator
	logic [16:0]     block_sum;
	int              block_count;
	charge_reading_t readings_due [$];
	bit              pinned_valid;
	charge_reading_t pinned_reading;

	// run control
	bit idle_on;
	bit rx_hold_req;
	bit rx_hold_done;
	int mismatches;
	int samples_sent;
	int blocks_sent;
	int estimates_checked;

	battery_charge_estimator DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.adc_sample     (adc_sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.charge_percent (charge_percent),
		.battery_mv     (battery_mv)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("[battery_charge_estimator] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Discharge curve, knee 0 at the top
	// ------------------------------------------------------------------
	function automatic int knee_mv(input int k);
		case (k)
			0:       return 4200;
			1:       return 4050;
			2:       return 3900;
			3:       return 3850;
			4:       return 3800;
			5:       return 3750;
			6:       return 3700;
			7:       return 3650;
			8:       return 3600;
			9:       return 3500;
			default: return 3300;
		endcase
	endfunction

	function automatic int knee_pct(input int k);
		case (k)
			0:       return 100;
			1:       return 90;
			2:       return 80;
			3:       return 70;
			4:       return 60;
			5:       return 50;
			6:       return 40;
			7:       return 30;
			8:       return 20;
			9:       return 10;
			default: return 0;
		endcase
	endfunction

	// percent from millivolts, linear between knees, floor division
	function automatic logic [PCT_W-1:0] charge_from_mv(input int mv);
		int k;
		int above;
		int below;
		int span;
		if (mv >= MV_TOP)
			return PCT_W'(PCT_TOP);
		if (mv <= MV_BOTTOM)
			return PCT_W'(PCT_BOTTOM);
		for (k = 1; k < KNEE_COUNT; k++) begin
			if (mv > knee_mv(k)) begin
				above = knee_mv(k - 1) - mv;
				below = mv - knee_mv(k);
				span  = above + below;
				// flat segment: take the lower knee
				if (span <= 0)
					return PCT_W'(knee_pct(k));
				return PCT_W'((knee_pct(k - 1) * below + knee_pct(k) * above) / span);
			end
		end
		return PCT_W'(PCT_BOTTOM);
	endfunction

	// fold one accepted sample into the model; the block's last one
	// queues an estimate
	task automatic accumulate_sample(input logic [SAMPLE_W-1:0] v);
		int avg;
		int mv;
		charge_reading_t r;
		block_sum   = block_sum + v;
		block_count = block_count + 1;
		samples_sent++;
		if (block_count == SAMPLES_PER_ESTIMATE) begin
			avg   = int'(block_sum) / SAMPLES_PER_ESTIMATE;
			mv    = (avg * MV_SCALE_NUM) / MV_SCALE_DEN;
			r.pct = charge_from_mv(mv);
			r.mv  = MV_W'(mv);
			if (pinned_valid) begin
				r = pinned_reading;
				pinned_valid = 1'b0;
			end
			readings_due.push_back(r);
			block_sum   = '0;
			block_count = 0;
			blocks_sent++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sender: called at a falling edge, returns at the falling edge after
	// the transfer. Valid stays high across back-to-back samples.
	// ------------------------------------------------------------------
	task automatic transfer_sample(input logic [SAMPLE_W-1:0] v);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid   = 1'b1;
		adc_sample = v;
		do
			@(posedge clk);
		while (!in_ready);
		accumulate_sample(v);
		@(negedge clk);
	endtask

	task automatic send_block(input logic [SAMPLE_W-1:0] base,
	                          input logic [SAMPLE_W-1:0] flip);
		int i;
		for (i = 0; i < SAMPLES_PER_ESTIMATE; i++)
			transfer_sample((i % 2) ? (base ^ flip) : base);
	endtask

	// clamp to the converter range
	function automatic logic [SAMPLE_W-1:0] adc_clamp(input int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return '1;
		return SAMPLE_W'(v);
	endfunction

	// random block: mostly samples clustered on a target around the curve,
	// some full-range noise, rails and knee edges
	task automatic send_random_block();
		int mode;
		int target;
		int spread;
		int i;
		mode   = $urandom_range(0, 9);
		target = $urandom_range(2080, 2740);
		spread = $urandom_range(0, 64);
		if (mode == 9) begin
			case ($urandom_range(0, 3))
				0:       target = 2121;
				1:       target = 2122;
				2:       target = 2699;
				default: target = 2700;
			endcase
			spread = $urandom_range(0, 2);
		end
		for (i = 0; i < SAMPLES_PER_ESTIMATE; i++) begin
			if (mode == 7)
				transfer_sample(SAMPLE_W'($urandom_range(0, 4095)));
			else if (mode == 8)
				transfer_sample($urandom_range(0, 1) ? '1 : '0);
			else
				transfer_sample(adc_clamp(target + $urandom_range(0, 2 * spread) - spread));
		end
	endtask

	// directed block table; knee rows fall on either side of a curve point
	function automatic block_row_t directed_row(input int idx);
		case (idx)
			0:       return '{12'd0,    12'h000, 1'b1, 7'd0,   13'd0};    // all zero
			1:       return '{12'd4095, 12'h000, 1'b1, 7'd100, 13'd6370}; // full scale
			2:       return '{12'd2700, 12'h000, 1'b1, 7'd100, 13'd4200}; // top knee exact
			3:       return '{12'd2122, 12'h000, 1'b1, 7'd0,   13'd3300}; // bottom knee exact
			4:       return '{12'd2699, 12'h000, 1'b0, 7'd0,   13'd0};    // just under top
			5:       return '{12'd2123, 12'h000, 1'b0, 7'd0,   13'd0};    // just over bottom
			6:       return '{12'd0,    12'hFFF, 1'b0, 7'd0,   13'd0};    // 0 / 4095 swing
			7:       return '{12'd2604, 12'h000, 1'b0, 7'd0,   13'd0};
			8:       return '{12'd2507, 12'h000, 1'b0, 7'd0,   13'd0};
			9:       return '{12'd2475, 12'h000, 1'b0, 7'd0,   13'd0};
			10:      return '{12'd2443, 12'h000, 1'b0, 7'd0,   13'd0};
			11:      return '{12'd2411, 12'h000, 1'b0, 7'd0,   13'd0};
			12:      return '{12'd2379, 12'h000, 1'b0, 7'd0,   13'd0};
			13:      return '{12'd2347, 12'h000, 1'b0, 7'd0,   13'd0};
			14:      return '{12'd2315, 12'h000, 1'b0, 7'd0,   13'd0};
			15:      return '{12'd2250, 12'h000, 1'b0, 7'd0,   13'd0};
			16:      return '{12'd2200, 12'h000, 1'b0, 7'd0,   13'd0};
			17:      return '{12'd2400, 12'h001, 1'b0, 7'd0,   13'd0};    // average floors
			default: return '{12'hAAA, 12'h555, 1'b0, 7'd0,   13'd0};    // bit pattern
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stalls, one long hold on request
	// ------------------------------------------------------------------
	initial begin
		out_ready    = 1'b0;
		rx_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req && !rx_hold_done) begin
				// long hold: the output register and the next estimate fill,
				// then in_ready has to drop
				out_ready = 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				@(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker, sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		charge_reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (readings_due.size() == 0) begin
				$display("%0t: estimate with none pending: pct %0d mv %0d",
				         $time, charge_percent, battery_mv);
				mismatches++;
			end else begin
				want = readings_due.pop_front();
				estimates_checked++;
				if (charge_percent !== want.pct) begin
					$display("%0t: charge_percent expected %0d got %0d",
					         $time, want.pct, charge_percent);
					mismatches++;
				end
				if (battery_mv !== want.mv) begin
					$display("%0t: battery_mv expected %0d got %0d",
					         $time, want.mv, battery_mv);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		block_row_t row;
		int r;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		adc_sample        = '0;
		block_sum         = '0;
		block_count       = 0;
		pinned_valid      = 1'b0;
		pinned_reading    = '0;
		idle_on           = 1'b1;
		rx_hold_req       = 1'b0;
		mismatches        = 0;
		samples_sent      = 0;
		blocks_sent       = 0;
		estimates_checked = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (r = 0; r < DIRECTED_ROWS; r++) begin
			row = directed_row(r);
			if (row.pinned) begin
				pinned_valid       = 1'b1;
				pinned_reading.pct = row.pct;
				pinned_reading.mv  = row.mv;
			end
			send_block(row.base, row.flip);
		end

		// random blocks with idling on both sides
		for (r = 0; r < RANDOM_BLOCKS; r++) begin
			if (r == HOLD_AT_BLOCK)
				rx_hold_req = 1'b1;
			if (r == PAUSE_AT_BLOCK) begin
				// sender goes quiet until every estimate is out
				in_valid = 1'b0;
				while (readings_due.size() != 0)
					@(negedge clk);
			end
			send_random_block();
		end

		// closing stretch at full rate
		idle_on = 1'b0;
		for (r = 0; r < CLEAN_BLOCKS; r++)
			send_random_block();
		in_valid = 1'b0;

		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d sample transfers in %0d blocks, %0d estimates checked",
		         samples_sent, blocks_sent, estimates_checked);
		$display("(curve knees, rails, bit patterns, long output hold, idle bursts).");
		if (mismatches == 0 && readings_due.size() == 0)
			$display("[battery_charge_estimator] OK");
		else
			$display("[battery_charge_estimator] ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/bce_pkg.sv
rtl/battery_charge_estimator.sv
tb/testbench.sv
